@@ design/sha256_pkg.sv @@
// Package: SHA-256 constants, types and round functions for the stream hasher.
`timescale 1ns / 1ps
package sha256_pkg;

   typedef logic [31:0] word_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_MARK,
      ST_PAD,
      ST_EMIT
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic       take_byte;   // write request byte into block, count it
      logic       pad_write;   // write padding byte at fill position
      logic       pad_mark;    // padding byte is the 0x80 marker
      logic       pad_len;     // this block carries the bit length in its tail
      logic       load;        // load working vars from chain
      logic       round;       // execute one round
      logic [5:0] round_idx;
      logic       fold;        // add working vars into chain
      logic       restart;     // return chain/fill/count to start values
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic [5:0] fill;
   } status_type;

   localparam word_type InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [7:0] PadByte   = 8'h80;
   localparam logic [5:0] LenOffset = 6'd56;

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type sig0(input word_type x);
      sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type sig1(input word_type x);
      sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type bsig0(input word_type x);
      bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type bsig1(input word_type x);
      bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage

@@ design/sha256_if.sv @@
// Interfaces: request and response channels of the stream hasher.
`timescale 1ns / 1ps
interface sha256_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       end_of_message;
   modport source  (output valid, data_byte, byte_valid, end_of_message, input ready);
   modport sink    (input valid, data_byte, byte_valid, end_of_message, output ready);
   modport monitor (input valid, data_byte, byte_valid, end_of_message, ready);
endinterface

interface sha256_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_part;
   logic [1:0]  part_index;
   logic        last_part;
   modport source  (output valid, digest_part, part_index, last_part, input ready);
   modport sink    (input valid, digest_part, part_index, last_part, output ready);
   modport monitor (input valid, digest_part, part_index, last_part, ready);
endinterface

@@ design/sha256_datapath.sv @@
// Datapath: block words / schedule window, round logic, chain words, counters.
`timescale 1ns / 1ps
module sha256_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  sha256_pkg::cmd_type    cmd,
   input  logic [7:0]             in_byte,
   output sha256_pkg::status_type status,
   output logic [255:0]           digest
);

   // Bytes are packed straight into the schedule window, which then rolls
   sha256_pkg::word_type w_ff [16];
   sha256_pkg::word_type v_ff [8];
   sha256_pkg::word_type h_ff [8];
   logic [5:0]  fill_ff;
   logic [63:0] total_ff;

   sha256_pkg::word_type w_cur, w_new, t1, t2;
   logic [63:0] bits;
   logic [7:0]  pad_val;
   logic [7:0]  wr_byte;
   logic [5:0]  fill_in;

   // Bit length, then the padding byte for the current fill position
   assign bits = {total_ff[60:0], 3'b000};
   always_comb begin
      if (cmd.pad_mark)
         pad_val = sha256_pkg::PadByte;
      else if (cmd.pad_len && fill_ff >= sha256_pkg::LenOffset)
         pad_val = bits[{~fill_ff[2:0], 3'b000} +: 8];
      else
         pad_val = 8'h00;
   end
   assign wr_byte = cmd.take_byte ? in_byte : pad_val;

   // Round arithmetic
   assign w_new = w_ff[0] + sha256_pkg::sig0(w_ff[1]) + w_ff[9] + sha256_pkg::sig1(w_ff[14]);
   assign w_cur = (cmd.round_idx < 6'd16) ? w_ff[0] : w_new;
   assign t1 = v_ff[7] + sha256_pkg::bsig1(v_ff[4])
             + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + sha256_pkg::RoundK[cmd.round_idx] + w_cur;
   assign t2 = sha256_pkg::bsig0(v_ff[0])
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   assign fill_in = fill_ff + 6'd1;

   // Fill count and byte count
   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         fill_ff  <= '0;
         total_ff <= '0;
      end else if (cmd.take_byte) begin
         fill_ff  <= fill_in;
         total_ff <= total_ff + 64'd1;
      end else if (cmd.pad_write) begin
         fill_ff <= fill_in;
      end
   end

   // Block words: byte writes big-endian within a word, schedule shift per round
   always_ff @(posedge clock) begin
      if (cmd.take_byte || cmd.pad_write) begin
         w_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= wr_byte;
      end else if (cmd.round) begin
         for (int i = 0; i < 15; i++)
            w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_cur;
      end
   end

   // Working variables
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < 8; i++)
            v_ff[i] <= h_ff[i];
      end else if (cmd.round) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   // Chain words
   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         for (int i = 0; i < 8; i++)
            h_ff[i] <= sha256_pkg::InitHash[i];
      end else if (cmd.fold) begin
         for (int i = 0; i < 8; i++)
            h_ff[i] <= h_ff[i] + v_ff[i];
      end
   end

   assign status.fill = fill_ff;
   assign digest = {h_ff[0], h_ff[1], h_ff[2], h_ff[3],
                    h_ff[4], h_ff[5], h_ff[6], h_ff[7]};

endmodule

@@ design/sha256_ctrl.sv @@
// Controller: sequences byte intake, padding, rounds and digest output.
`timescale 1ns / 1ps
module sha256_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   sha256_req_if.sink             req,
   sha256_rsp_if.source           rsp,
   input  sha256_pkg::status_type status,
   input  logic [255:0]           digest,
   output sha256_pkg::cmd_type    cmd
);

   sha256_pkg::state_type state_ff, state_in;
   logic [5:0] round_ff, round_in;
   logic [1:0] part_ff, part_in;
   logic       fin_ff, fin_in;         // end of message seen, digest owed
   logic       marked_ff, marked_in;   // 0x80 already written
   logic       lenblk_ff, lenblk_in;   // current pad block carries the length
   logic       accept;
   logic       block_done;             // a write now lands on the last slot

   assign accept     = req.valid && req.ready;
   assign block_done = (status.fill == 6'd63);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sha256_pkg::ST_IDLE;
         round_ff  <= '0;
         part_ff   <= '0;
         fin_ff    <= 1'b0;
         marked_ff <= 1'b0;
         lenblk_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         round_ff  <= round_in;
         part_ff   <= part_in;
         fin_ff    <= fin_in;
         marked_ff <= marked_in;
         lenblk_ff <= lenblk_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      round_in  = round_ff;
      part_in   = part_ff;
      fin_in    = fin_ff;
      marked_in = marked_ff;
      lenblk_in = lenblk_ff;
      cmd       = '0;
      cmd.round_idx = round_ff;
      req.ready = 1'b0;
      rsp.valid = 1'b0;
      case (state_ff)
         sha256_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            if (accept) begin
               cmd.take_byte = req.byte_valid;
               if (req.end_of_message)
                  fin_in = 1'b1;
               if (req.byte_valid && block_done)
                  state_in = sha256_pkg::ST_LOAD;
               else if (req.end_of_message)
                  state_in = sha256_pkg::ST_MARK;
            end
         end
         sha256_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
            round_in = '0;
            state_in = sha256_pkg::ST_ROUND;
         end
         sha256_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
            round_in  = round_ff + 6'd1;
            if (round_ff == 6'd63)
               state_in = sha256_pkg::ST_FOLD;
         end
         sha256_pkg::ST_FOLD: begin
            cmd.fold = 1'b1;
            if (!fin_ff) begin
               state_in = sha256_pkg::ST_IDLE;
            end else if (!marked_ff) begin
               // last byte filled the block; padding starts fresh
               state_in = sha256_pkg::ST_MARK;
            end else if (lenblk_ff) begin
               part_in  = '0;
               state_in = sha256_pkg::ST_EMIT;
            end else begin
               // no room was left for the length: one more block of zeros
               lenblk_in = 1'b1;
               state_in  = sha256_pkg::ST_PAD;
            end
         end
         sha256_pkg::ST_MARK: begin
            // 0x80 marker; length fits only if at least eight bytes remain after it
            cmd.pad_write = 1'b1;
            cmd.pad_mark  = 1'b1;
            marked_in     = 1'b1;
            lenblk_in     = (status.fill < sha256_pkg::LenOffset);
            state_in      = block_done ? sha256_pkg::ST_LOAD : sha256_pkg::ST_PAD;
         end
         sha256_pkg::ST_PAD: begin
            // zeros, then the length bytes in the tail of the length block
            cmd.pad_write = 1'b1;
            cmd.pad_len   = lenblk_ff;
            if (block_done)
               state_in = sha256_pkg::ST_LOAD;
         end
         sha256_pkg::ST_EMIT: begin
            rsp.valid = 1'b1;
            if (rsp.ready) begin
               part_in = part_ff + 2'd1;
               if (part_ff == 2'd3) begin
                  cmd.restart = 1'b1;
                  fin_in    = 1'b0;
                  marked_in = 1'b0;
                  lenblk_in = 1'b0;
                  state_in  = sha256_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = sha256_pkg::ST_IDLE;
      endcase
   end

   assign rsp.digest_part = digest[{~part_ff, 6'b000000} +: 64];
   assign rsp.part_index  = part_ff;
   assign rsp.last_part   = (part_ff == 2'd3);

   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> state_ff == sha256_pkg::ST_EMIT)
      else $error("response outside emit");
   assert property (@(posedge clock) disable iff (reset)
      cmd.round |-> !req.ready)
      else $error("accepting during rounds");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha256_pkg::ST_ROUND && round_ff == 6'd63) |=> state_ff == sha256_pkg::ST_FOLD)
      else $error("round count slip");
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.part_index)))
      else $error("response dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha256_pkg::ST_MARK || state_ff == sha256_pkg::ST_PAD) |-> fin_ff)
      else $error("padding without end of message");

endmodule

@@ design/sha256_stream_hasher_top.sv @@
// Top level: SHA-256 stream hasher.
`timescale 1ns / 1ps
// Takes one message byte per request, one request per cycle while idle. The request
// that completes a 64-byte block is followed by ready low for the compression (load,
// 64 rounds on one shared round unit, fold). End of message writes the 0x80 marker,
// then zero pad bytes to the block end with the bit length in the last eight, and
// compresses the block; when fewer than eight bytes remain after the marker, these
// are zeros and a second block of zeros with the bit length in its tail follows and
// is compressed. The digest then goes out as four 64-bit big-endian responses, part 0
// first, one per cycle while the receiver is ready; no request is taken until the
// last part is accepted.
module sha256_stream_hasher_top (
   input logic          clock,
   input logic          reset,
   sha256_req_if.sink   req,
   sha256_rsp_if.source rsp
);
   sha256_pkg::cmd_type    cmd;
   sha256_pkg::status_type status;
   logic [255:0]           digest;

   sha256_ctrl u_ctrl (.clock, .reset, .req, .rsp, .status, .digest, .cmd);
   sha256_datapath u_dp (.clock, .reset, .cmd, .in_byte(req.data_byte), .status, .digest);
endmodule

@@ verif/sha256_stream_hasher_checker.sv @@
// Checker: watches the stream hasher channels, predicts digests and compares responses.
`timescale 1ns / 1ps
module sha256_stream_hasher_checker (
   input logic           clock,
   input logic           reset,
   sha256_req_if.monitor req_mon,
   sha256_rsp_if.monitor rsp_mon,
   output int            fail_count,
   output int            pending_parts
);

   typedef struct {
      logic [63:0] digest_part;
      logic [1:0]  part_index;
      logic        last_part;
   } digest_beat_type;

   // Running hash state of the message in flight
   sha256_pkg::word_type chain_q [8];
   logic [7:0]  block_q [64];
   int          fill_q;
   logic [63:0] msg_bytes_q;

   digest_beat_type digest_queue [$];

   function automatic sha256_pkg::word_type ror32(sha256_pkg::word_type x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // One SHA-256 compression of block_q into chain_q
   task automatic compress_block_q();
      sha256_pkg::word_type w [64];
      sha256_pkg::word_type v [8];
      sha256_pkg::word_type t1, t2, e_mix, a_mix;
      for (int i = 0; i < 16; i++)
         w[i] = {block_q[4*i], block_q[4*i+1], block_q[4*i+2], block_q[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = w[i-16] + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
              + w[i-7] + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
      v = chain_q;
      for (int i = 0; i < 64; i++) begin
         e_mix = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
         a_mix = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
         t1 = v[7] + e_mix + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::RoundK[i] + w[i];
         t2 = a_mix + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++)
         chain_q[i] = chain_q[i] + v[i];
   endtask

   task automatic start_new_message();
      chain_q     = sha256_pkg::InitHash;
      fill_q      = 0;
      msg_bytes_q = '0;
   endtask

   // Fold one request into the running hash, queue the digest on end of message
   task automatic hash_request(logic [7:0] data, logic has_byte, logic eom);
      logic [63:0]     bit_len;
      digest_beat_type beat;
      if (has_byte) begin
         block_q[fill_q] = data;
         msg_bytes_q++;
         fill_q++;
         if (fill_q == 64) begin
            compress_block_q();
            fill_q = 0;
         end
      end
      if (eom) begin
         bit_len = msg_bytes_q << 3;
         block_q[fill_q] = sha256_pkg::PadByte;
         fill_q++;
         if (fill_q > 56) begin
            while (fill_q < 64) block_q[fill_q++] = 8'h00;
            compress_block_q();
            fill_q = 0;
         end
         while (fill_q < 56) block_q[fill_q++] = 8'h00;
         for (int i = 0; i < 8; i++)
            block_q[56+i] = bit_len[8*(7-i) +: 8];
         compress_block_q();
         for (int k = 0; k < 4; k++) begin
            beat.digest_part = {chain_q[2*k], chain_q[2*k+1]};
            beat.part_index  = 2'(k);
            beat.last_part   = (k == 3);
            digest_queue.push_back(beat);
         end
         start_new_message();
      end
   endtask

   initial begin
      fail_count    = 0;
      pending_parts = 0;
      start_new_message();
   end

   // Sample both channels at the clock edge
   always @(posedge clock) begin
      digest_beat_type want;
      if (reset) begin
         start_new_message();
         digest_queue.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            hash_request(req_mon.data_byte, req_mon.byte_valid, req_mon.end_of_message);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (digest_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected digest part %h index %0d", rsp_mon.digest_part,
                           rsp_mon.part_index);
            end else begin
               want = digest_queue.pop_front();
               if (want.digest_part !== rsp_mon.digest_part ||
                   want.part_index !== rsp_mon.part_index ||
                   want.last_part !== rsp_mon.last_part) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("digest mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
                              want.digest_part, want.part_index, want.last_part,
                              rsp_mon.digest_part, rsp_mon.part_index, rsp_mon.last_part);
               end
            end
         end
      end
      pending_parts = digest_queue.size();
   end

endmodule

@@ verif/testbench.sv @@
// Testbench top: drives requests into the stream hasher and reports the verdict.
`timescale 1ns / 1ps
module testbench;

   localparam int WatchdogLimit = 20000;
   localparam int RandomItems   = 60;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_parts;
   int   idle_cycles;
   bit   calm_stretch;
   bit   hold_off;

   sha256_req_if req_ch ();
   sha256_rsp_if rsp_ch ();

   sha256_stream_hasher_top i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   sha256_stream_hasher_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch.monitor),
      .rsp_mon       (rsp_ch.monitor),
      .fail_count    (fail_count),
      .pending_parts (pending_parts)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.data_byte      = '0;
      req_ch.byte_valid     = 1'b0;
      req_ch.end_of_message = 1'b0;
      rsp_ch.ready          = 1'b0;
      calm_stretch          = 1'b0;
      hold_off              = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Send one request; random gaps before it unless in the calm stretch
   task automatic send_request(logic [7:0] data, logic has_byte, logic eom);
      logic took;
      while (!calm_stretch && $urandom_range(99) < 15) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.data_byte      <= data;
      req_ch.byte_valid     <= has_byte;
      req_ch.end_of_message <= eom;
      // ready settles after the edge and holds until the next one
      do begin
         @(negedge clock);
         took = req_ch.ready;
         @(posedge clock);
      end while (!took);
   endtask

   task automatic send_message(int len, bit eom_with_byte, bit all_ones);
      for (int i = 0; i < len; i++) begin
         if (eom_with_byte && i == len - 1)
            send_request(all_ones ? 8'hff : 8'($urandom), 1'b1, 1'b1);
         else
            send_request(all_ones ? 8'hff : 8'($urandom), 1'b1, 1'b0);
      end
      if (!eom_with_byte || len == 0)
         send_request(8'($urandom), 1'b0, 1'b1);
   endtask

   // Receiver: random stalls, one long hold-off while requests keep coming
   always @(posedge clock) begin
      if (reset)
         rsp_ch.ready <= 1'b0;
      else if (hold_off)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= calm_stretch || ($urandom_range(99) >= 15);
   end

   initial begin
      int len;
      @(negedge reset);
      @(posedge clock);
      // Directed: empty message, ignored item, boundary lengths, extremes of the byte
      send_request(8'h5a, 1'b0, 1'b0);
      send_message(0, 1'b0, 1'b0);
      send_message(1, 1'b1, 1'b0);
      send_request(8'h00, 1'b1, 1'b0);
      send_request(8'hff, 1'b0, 1'b1);
      send_message(55, 1'b1, 1'b1);
      send_message(56, 1'b0, 1'b0);
      send_message(63, 1'b1, 1'b0);
      send_message(64, 1'b0, 1'b1);
      // Long receiver hold-off while short messages keep arriving
      hold_off = 1'b1;
      fork
         begin
            repeat (600) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            send_message(3, 1'b1, 1'b0);
            send_message(2, 1'b1, 1'b0);
            send_message(5, 1'b0, 1'b0);
         end
      join
      // Random messages, mostly short, a few crossing block boundaries
      for (int n = 0; n < RandomItems; n += len + 1) begin
         calm_stretch = (n > 15 && n < 40);
         len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(12);
         if ($urandom_range(7) == 0)
            send_request(8'($urandom), 1'b0, 1'b0);
         send_message(len, 1'($urandom), 1'b0);
      end
      calm_stretch = 1'b0;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_parts != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("sha256_stream_hasher_top regression: pass");
      else
         $display("sha256_stream_hasher_top regression: fail");
      $finish;
   end

   // Watchdog on cycles with no accepted request or response
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("sha256_stream_hasher_top regression: fail");
         $finish;
      end
   end

endmodule
